>>> rtl/cwa_pkg.sv
// Package for the collider world bounds pipeline: lane formats, datapath widths,
// shape kind codes, the rotation matrix entry function and saturation helpers.
// Depends on nothing.
package cwa_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int QUAT_BITS  = 15;
    localparam int QUAT_FRAC  = 13;
    localparam int AXIS_BITS  = 16;
    localparam int AXIS_FRAC  = 14;

    localparam int QSH  = 2 * QUAT_FRAC;
    localparam int RW   = 2 * QUAT_BITS + 4;
    localparam int CPW  = RW + COORD_BITS;
    localparam int CSW  = CPW + 3;
    localparam int AW   = CSW - QSH;
    localparam int BPW  = RW + AW;
    localparam int BSW  = BPW + 3;
    localparam int BW   = BSW - QSH;
    localparam int HPW  = AXIS_BITS + COORD_BITS;
    localparam int HW   = HPW + 1 - AXIS_FRAC;
    localparam int HRPW = RW + HW;
    localparam int HSW  = HRPW + 3;
    localparam int HRW  = HSW - QSH;
    localparam int CEW  = CSW - QSH + 1;

    localparam logic signed [COORD_BITS-1:0] LANE_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [63:0] LMAX64 = 64'(LANE_MAX);
    localparam logic signed [63:0] LMIN64 = -LMAX64 - 64'sd1;
    localparam logic [COORD_BITS-1:0] UNIT_EXT = (FRAC_BITS < COORD_BITS - 1) ?
        (COORD_BITS'(1) << FRAC_BITS) : LANE_MAX;

    typedef enum logic [1:0] {
        KIND_PLANE   = 2'd0,
        KIND_SPHERE  = 2'd1,
        KIND_BOX     = 2'd2,
        KIND_CAPSULE = 2'd3
    } kind_t;

    // Entry (i,j) of the unnormalized rotation matrix, scaled by 2^QSH.
    function automatic logic signed [RW-1:0] rot_entry(
        input logic signed [QUAT_BITS-1:0] qw,
        input logic signed [QUAT_BITS-1:0] qx,
        input logic signed [QUAT_BITS-1:0] qy,
        input logic signed [QUAT_BITS-1:0] qz,
        input int i,
        input int j
    );
        logic signed [RW-1:0] w, v0, v1, v2, n2, qi, qj, qk, val;
        w  = RW'(qw);
        v0 = RW'(qx);
        v1 = RW'(qy);
        v2 = RW'(qz);
        n2 = v0 * v0 + v1 * v1 + v2 * v2;
        qi = (i == 0) ? v0 : ((i == 1) ? v1 : v2);
        qj = (j == 0) ? v0 : ((j == 1) ? v1 : v2);
        qk = (i + j == 1) ? v2 : ((i + j == 2) ? v1 : v0);
        val = (qi * qj) <<< 1;
        if (i == j) begin
            val = val + (RW'(1) <<< QSH) - (n2 <<< 1);
        end else if ((i == 0 && j == 1) || (i == 1 && j == 2) || (i == 2 && j == 0)) begin
            val = val - ((w * qk) <<< 1);
        end else begin
            val = val + ((w * qk) <<< 1);
        end
        return val;
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [63:0] x);
        if (x > LMAX64) begin
            return LANE_MAX;
        end else if (x < LMIN64) begin
            return ~LANE_MAX;
        end
        return x[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_ext(input logic signed [63:0] x);
        if (x > LMAX64) begin
            return LANE_MAX;
        end else if (x < 64'sd0) begin
            return '0;
        end
        return x[COORD_BITS-1:0];
    endfunction

endpackage

>>> rtl/collider_world_aabb.sv
// Throughput: one item per cycle; all six register stages advance together
// whenever the output register is empty or its result is being taken.
// Reset (aresetn low, synchronous) clears all stage valid bits; data regs hold.
// Stages: matrix build, first products, box corner round, second products,
// corner round and abs, max over corners and output.
module collider_world_aabb (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_func,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_shape_center,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_shape_size,
    input  logic [4*cwa_pkg::QUAT_BITS-1:0]        s_shape_rotation,
    input  logic [3*cwa_pkg::AXIS_BITS-1:0]        s_shape_axis,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_xform_position,
    input  logic [4*cwa_pkg::QUAT_BITS-1:0]        s_xform_rotation,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [3*cwa_pkg::COORD_BITS-1:0]       m_bounds_center,
    output logic [3*cwa_pkg::COORD_BITS-1:0]       m_bounds_extents
);

    localparam int CB = cwa_pkg::COORD_BITS;
    localparam int QB = cwa_pkg::QUAT_BITS;
    localparam int AB = cwa_pkg::AXIS_BITS;
    localparam int RW = cwa_pkg::RW;
    localparam int QSH = cwa_pkg::QSH;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;

    // stage 1
    logic signed [RW-1:0]           rx1_reg [3][3];
    logic signed [RW-1:0]           rb1_reg [3][3];
    logic signed [RW-1:0]           rx1_next [3][3];
    logic signed [RW-1:0]           rb1_next [3][3];
    logic signed [CB-1:0]           ctr1_reg [3];
    logic signed [CB-1:0]           size1_reg [3];
    logic signed [CB-1:0]           pos1_reg [3];
    logic signed [cwa_pkg::HPW-1:0] hp1_reg [3];
    logic signed [cwa_pkg::HPW-1:0] hp1_next [3];
    logic [1:0]                     kind1_reg;

    // stage 2
    logic signed [cwa_pkg::CPW-1:0] colc2_reg [3][3];
    logic signed [cwa_pkg::CPW-1:0] colb2_reg [3][3];
    logic signed [cwa_pkg::CPW-1:0] colc2_next [3][3];
    logic signed [cwa_pkg::CPW-1:0] colb2_next [3][3];
    logic signed [cwa_pkg::HW-1:0]  h2_reg [3];
    logic signed [cwa_pkg::HW-1:0]  h2_next [3];
    logic signed [RW-1:0]           rx2_reg [3][3];
    logic signed [CB-1:0]           size2_reg [2];
    logic signed [CB-1:0]           pos2_reg [3];
    logic [1:0]                     kind2_reg;

    // stage 3
    logic [CB-1:0]                   cen3_reg [3];
    logic [CB-1:0]                   cen3_next [3];
    logic signed [cwa_pkg::AW-1:0]   a3_reg [8][3];
    logic signed [cwa_pkg::AW-1:0]   a3_next [8][3];
    logic signed [cwa_pkg::HRPW-1:0] hr3_reg [3][3];
    logic signed [cwa_pkg::HRPW-1:0] hr3_next [3][3];
    logic signed [RW-1:0]            rx3_reg [3][3];
    logic signed [CB-1:0]            size3_reg [2];
    logic [1:0]                      kind3_reg;

    // stage 4
    logic signed [cwa_pkg::BPW-1:0] b4_reg [8][3][3];
    logic signed [cwa_pkg::BPW-1:0] b4_next [8][3][3];
    logic [CB-1:0]                  cap4_reg [3];
    logic [CB-1:0]                  cap4_next [3];
    logic [CB-1:0]                  cen4_reg [3];
    logic signed [CB-1:0]           size4_reg;
    logic [1:0]                     kind4_reg;

    // stage 5
    logic [cwa_pkg::BW-1:0] abs5_reg [8][3];
    logic [cwa_pkg::BW-1:0] abs5_next [8][3];
    logic [CB-1:0]          cap5_reg [3];
    logic [CB-1:0]          cen5_reg [3];
    logic signed [CB-1:0]   size5_reg;
    logic [1:0]             kind5_reg;

    // output stage
    logic [3*CB-1:0] center_reg, center_next;
    logic [3*CB-1:0] extents_reg, extents_next;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_valid_reg;
    assign m_bounds_center  = center_reg;
    assign m_bounds_extents = extents_reg;

    // stage 1: rotation matrices and capsule axis products
    always_comb begin
        logic signed [QB-1:0] xw, xx, xy, xz, bw, bx, by, bz;
        xw = $signed(s_xform_rotation[0*QB +: QB]);
        xx = $signed(s_xform_rotation[1*QB +: QB]);
        xy = $signed(s_xform_rotation[2*QB +: QB]);
        xz = $signed(s_xform_rotation[3*QB +: QB]);
        bw = $signed(s_shape_rotation[0*QB +: QB]);
        bx = $signed(s_shape_rotation[1*QB +: QB]);
        by = $signed(s_shape_rotation[2*QB +: QB]);
        bz = $signed(s_shape_rotation[3*QB +: QB]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rx1_next[i][j] = cwa_pkg::rot_entry(xw, xx, xy, xz, i, j);
                rb1_next[i][j] = cwa_pkg::rot_entry(bw, bx, by, bz, i, j);
            end
            hp1_next[i] = cwa_pkg::HPW'($signed(s_shape_axis[i*AB +: AB]))
                        * cwa_pkg::HPW'($signed(s_shape_size[0 +: CB]));
        end
    end

    // stage 2: matrix column products, capsule half-height round
    always_comb begin
        logic signed [cwa_pkg::HPW:0] ht;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                colc2_next[i][j] = cwa_pkg::CPW'(rx1_reg[i][j]) * cwa_pkg::CPW'(ctr1_reg[j]);
                colb2_next[i][j] = cwa_pkg::CPW'(rb1_reg[i][j]) * cwa_pkg::CPW'(size1_reg[j]);
            end
            ht = (cwa_pkg::HPW+1)'(hp1_reg[i])
               + ((cwa_pkg::HPW+1)'(1) <<< (cwa_pkg::AXIS_FRAC - 1));
            h2_next[i] = $signed(ht[cwa_pkg::HPW:cwa_pkg::AXIS_FRAC]);
        end
    end

    // stage 3: center finish, box corners after first rotation, capsule products
    always_comb begin
        logic signed [cwa_pkg::CSW-1:0] sc;
        logic signed [cwa_pkg::CEW-1:0] ce;
        for (int i = 0; i < 3; i++) begin
            sc = cwa_pkg::CSW'(colc2_reg[i][0]) + cwa_pkg::CSW'(colc2_reg[i][1])
               + cwa_pkg::CSW'(colc2_reg[i][2]) + (cwa_pkg::CSW'(1) <<< (QSH - 1));
            ce = cwa_pkg::CEW'($signed(sc[cwa_pkg::CSW-1:QSH])) + cwa_pkg::CEW'(pos2_reg[i]);
            cen3_next[i] = cwa_pkg::sat_coord(64'(ce));
            for (int j = 0; j < 3; j++) begin
                hr3_next[i][j] = cwa_pkg::HRPW'(rx2_reg[i][j]) * cwa_pkg::HRPW'(h2_reg[j]);
            end
        end
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                sc = cwa_pkg::CSW'(1) <<< (QSH - 1);
                for (int j = 0; j < 3; j++) begin
                    if (((k >> (2 - j)) & 1) == 1) begin
                        sc = sc + cwa_pkg::CSW'(colb2_reg[i][j]);
                    end else begin
                        sc = sc - cwa_pkg::CSW'(colb2_reg[i][j]);
                    end
                end
                a3_next[k][i] = $signed(sc[cwa_pkg::CSW-1:QSH]);
            end
        end
    end

    // stage 4: second rotation products, capsule extents
    always_comb begin
        logic signed [cwa_pkg::HSW-1:0] sh;
        logic signed [cwa_pkg::HRW-1:0] r;
        logic signed [cwa_pkg::HRW:0]   ra;
        logic signed [cwa_pkg::HRW+1:0] cs;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    b4_next[k][i][j] = cwa_pkg::BPW'(rx3_reg[i][j])
                                     * cwa_pkg::BPW'(a3_reg[k][j]);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            sh = cwa_pkg::HSW'(hr3_reg[i][0]) + cwa_pkg::HSW'(hr3_reg[i][1])
               + cwa_pkg::HSW'(hr3_reg[i][2]) + (cwa_pkg::HSW'(1) <<< (QSH - 1));
            r  = $signed(sh[cwa_pkg::HSW-1:QSH]);
            ra = (r < 0) ? -(cwa_pkg::HRW+1)'(r) : (cwa_pkg::HRW+1)'(r);
            cs = (cwa_pkg::HRW+2)'(ra) + (cwa_pkg::HRW+2)'(size3_reg[1]);
            cap4_next[i] = cwa_pkg::sat_ext(64'(cs));
        end
    end

    // stage 5: round and take magnitude of each rotated corner
    always_comb begin
        logic signed [cwa_pkg::BSW-1:0] sb;
        logic signed [cwa_pkg::BW-1:0]  bv;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                sb = cwa_pkg::BSW'(b4_reg[k][i][0]) + cwa_pkg::BSW'(b4_reg[k][i][1])
                   + cwa_pkg::BSW'(b4_reg[k][i][2]) + (cwa_pkg::BSW'(1) <<< (QSH - 1));
                bv = $signed(sb[cwa_pkg::BSW-1:QSH]);
                abs5_next[k][i] = (bv < 0) ? -bv : bv;
            end
        end
    end

    // stage 6: max over corners, select extents by kind
    always_comb begin
        logic [cwa_pkg::BW-1:0] m4 [4];
        logic [cwa_pkg::BW-1:0] m2 [2];
        logic [cwa_pkg::BW-1:0] m1;
        logic [CB-1:0]          box_ext;
        logic [CB-1:0]          ext;
        for (int i = 0; i < 3; i++) begin
            for (int n = 0; n < 4; n++) begin
                m4[n] = (abs5_reg[2*n][i] > abs5_reg[2*n+1][i]) ?
                        abs5_reg[2*n][i] : abs5_reg[2*n+1][i];
            end
            for (int n = 0; n < 2; n++) begin
                m2[n] = (m4[2*n] > m4[2*n+1]) ? m4[2*n] : m4[2*n+1];
            end
            m1 = (m2[0] > m2[1]) ? m2[0] : m2[1];
            box_ext = (m1 > cwa_pkg::BW'(cwa_pkg::LANE_MAX)) ?
                      cwa_pkg::LANE_MAX : m1[CB-1:0];
            unique case (cwa_pkg::kind_t'(kind5_reg))
                cwa_pkg::KIND_PLANE:   ext = cwa_pkg::UNIT_EXT;
                cwa_pkg::KIND_SPHERE:  ext = cwa_pkg::sat_ext(64'(size5_reg));
                cwa_pkg::KIND_BOX:     ext = box_ext;
                cwa_pkg::KIND_CAPSULE: ext = cap5_reg[i];
                default:               ext = cwa_pkg::UNIT_EXT;
            endcase
            extents_next[i*CB +: CB] = ext;
            center_next[i*CB +: CB]  = cen5_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind1_reg <= s_func;
            for (int i = 0; i < 3; i++) begin
                ctr1_reg[i]  <= $signed(s_shape_center[i*CB +: CB]);
                size1_reg[i] <= $signed(s_shape_size[i*CB +: CB]);
                pos1_reg[i]  <= $signed(s_xform_position[i*CB +: CB]);
                hp1_reg[i]   <= hp1_next[i];
                for (int j = 0; j < 3; j++) begin
                    rx1_reg[i][j] <= rx1_next[i][j];
                    rb1_reg[i][j] <= rb1_next[i][j];
                end
            end

            kind2_reg    <= kind1_reg;
            size2_reg[0] <= size1_reg[0];
            size2_reg[1] <= size1_reg[1];
            for (int i = 0; i < 3; i++) begin
                h2_reg[i]   <= h2_next[i];
                pos2_reg[i] <= pos1_reg[i];
                for (int j = 0; j < 3; j++) begin
                    colc2_reg[i][j] <= colc2_next[i][j];
                    colb2_reg[i][j] <= colb2_next[i][j];
                    rx2_reg[i][j]   <= rx1_reg[i][j];
                end
            end

            kind3_reg    <= kind2_reg;
            size3_reg[0] <= size2_reg[0];
            size3_reg[1] <= size2_reg[1];
            for (int i = 0; i < 3; i++) begin
                cen3_reg[i] <= cen3_next[i];
                for (int j = 0; j < 3; j++) begin
                    hr3_reg[i][j] <= hr3_next[i][j];
                    rx3_reg[i][j] <= rx2_reg[i][j];
                end
            end
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 3; i++) begin
                    a3_reg[k][i] <= a3_next[k][i];
                end
            end

            kind4_reg <= kind3_reg;
            size4_reg <= size3_reg[0];
            for (int i = 0; i < 3; i++) begin
                cap4_reg[i] <= cap4_next[i];
                cen4_reg[i] <= cen3_reg[i];
            end
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        b4_reg[k][i][j] <= b4_next[k][i][j];
                    end
                end
            end

            kind5_reg <= kind4_reg;
            size5_reg <= size4_reg;
            for (int i = 0; i < 3; i++) begin
                cap5_reg[i] <= cap4_reg[i];
                cen5_reg[i] <= cen4_reg[i];
            end
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 3; i++) begin
                    abs5_reg[k][i] <= abs5_next[k][i];
                end
            end

            center_reg  <= center_next;
            extents_reg <= extents_next;
        end
    end

endmodule

>>> rtl/cwa_checker.sv
// Port-level checks for collider_world_aabb, attached by bind.
// Depends on cwa_pkg and the top level's port list.
module cwa_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [1:0]                       s_func,
    input logic [3*cwa_pkg::COORD_BITS-1:0] s_shape_center,
    input logic [3*cwa_pkg::COORD_BITS-1:0] s_shape_size,
    input logic [4*cwa_pkg::QUAT_BITS-1:0]  s_shape_rotation,
    input logic [3*cwa_pkg::AXIS_BITS-1:0]  s_shape_axis,
    input logic [3*cwa_pkg::COORD_BITS-1:0] s_xform_position,
    input logic [4*cwa_pkg::QUAT_BITS-1:0]  s_xform_rotation,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [3*cwa_pkg::COORD_BITS-1:0] m_bounds_center,
    input logic [3*cwa_pkg::COORD_BITS-1:0] m_bounds_extents
);

    localparam int CB = cwa_pkg::COORD_BITS;

    // hold result while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bounds_center)
                                && $stable(m_bounds_extents))
        else $error("result changed while stalled");

    // backpressure only from a stalled result
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // drop all results on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // extents never negative
    a_ext_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_bounds_extents[CB-1] && !m_bounds_extents[2*CB-1]
                    && !m_bounds_extents[3*CB-1])
        else $error("negative extent");

endmodule

bind collider_world_aabb cwa_checker u_cwa_checker (.*);

>>> test/collider_world_aabb_checker.sv
`timescale 1ns / 100ps
// Bounds checker for collider_world_aabb: it watches both channels, predicts
// the world bounds of each input transfer and compares them with the results.
// Depends on cwa_pkg for lane widths and shape kind codes.
module collider_world_aabb_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [1:0]                             s_func,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_shape_center,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_shape_size,
    input  logic [4*cwa_pkg::QUAT_BITS-1:0]        s_shape_rotation,
    input  logic [3*cwa_pkg::AXIS_BITS-1:0]        s_shape_axis,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       s_xform_position,
    input  logic [4*cwa_pkg::QUAT_BITS-1:0]        s_xform_rotation,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       m_bounds_center,
    input  logic [3*cwa_pkg::COORD_BITS-1:0]       m_bounds_extents,
    output int                                     fail_count,
    output int                                     bounds_pending
);

    localparam int CB = cwa_pkg::COORD_BITS;
    localparam int QB = cwa_pkg::QUAT_BITS;
    localparam int AB = cwa_pkg::AXIS_BITS;
    localparam longint LANE_HI = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint LANE_LO = -LANE_HI - 1;

    typedef struct {
        logic [3*CB-1:0] center;
        logic [3*CB-1:0] extents;
    } bounds_t;

    bounds_t bounds_q[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    function automatic longint round_off(input longint x, input int sh);
        return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic void unpack_coord(input logic [3*CB-1:0] w, output longint v[3]);
        for (int i = 0; i < 3; i++) v[i] = longint'($signed(w[i*CB +: CB]));
    endfunction

    function automatic void unpack_quat(input logic [4*QB-1:0] w, output longint q[4]);
        for (int i = 0; i < 4; i++) q[i] = longint'($signed(w[i*QB +: QB]));
    endfunction

    function automatic void turn(input longint q[4], input longint v[3], output longint o[3]);
        longint c[3];
        longint d[3];
        c[0] = q[2] * v[2] - q[3] * v[1];
        c[1] = q[3] * v[0] - q[1] * v[2];
        c[2] = q[1] * v[1] - q[2] * v[0];
        d[0] = q[2] * c[2] - q[3] * c[1];
        d[1] = q[3] * c[0] - q[1] * c[2];
        d[2] = q[1] * c[1] - q[2] * c[0];
        for (int i = 0; i < 3; i++)
            o[i] = round_off((v[i] <<< (2 * cwa_pkg::QUAT_FRAC)) + 2 * q[0] * c[i] + 2 * d[i],
                             2 * cwa_pkg::QUAT_FRAC);
    endfunction

    function automatic logic [CB-1:0] clamp(input longint x, input longint lo);
        longint y;
        y = (x > LANE_HI) ? LANE_HI : ((x < lo) ? lo : x);
        return y[CB-1:0];
    endfunction

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic bounds_t world_bounds(
        input cwa_pkg::kind_t kind,
        input logic [3*CB-1:0] ctr_w, size_w, pos_w,
        input logic [4*QB-1:0] qb_w, qx_w,
        input logic [3*AB-1:0] ax_w
    );
        bounds_t res;
        longint ctr[3], size[3], pos[3], cen[3], ext[3], p[3], a[3], b[3], h[3];
        longint qx[4], qb[4];
        unpack_coord(ctr_w, ctr);
        unpack_coord(size_w, size);
        unpack_coord(pos_w, pos);
        unpack_quat(qx_w, qx);
        unpack_quat(qb_w, qb);
        turn(qx, ctr, cen);
        for (int i = 0; i < 3; i++) begin
            cen[i] += pos[i];
            ext[i] = 0;
        end
        case (kind)
            cwa_pkg::KIND_PLANE: begin
                for (int i = 0; i < 3; i++) ext[i] = 64'sd1 <<< cwa_pkg::FRAC_BITS;
            end
            cwa_pkg::KIND_SPHERE: begin
                for (int i = 0; i < 3; i++) ext[i] = size[0];
            end
            cwa_pkg::KIND_BOX: begin
                for (int k = 0; k < 8; k++) begin
                    p[0] = k[2] ? size[0] : -size[0];
                    p[1] = k[1] ? size[1] : -size[1];
                    p[2] = k[0] ? size[2] : -size[2];
                    turn(qb, p, a);
                    turn(qx, a, b);
                    for (int i = 0; i < 3; i++)
                        if (mag(b[i]) > ext[i]) ext[i] = mag(b[i]);
                end
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    h[i] = round_off(longint'($signed(ax_w[i*AB +: AB]))
                                     * size[0], cwa_pkg::AXIS_FRAC);
                turn(qx, h, a);
                for (int i = 0; i < 3; i++) ext[i] = mag(a[i]) + size[1];
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            res.center[i*CB +: CB]  = clamp(cen[i], LANE_LO);
            res.extents[i*CB +: CB] = clamp(ext[i], 0);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        bounds_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                bounds_q.push_back(world_bounds(cwa_pkg::kind_t'(s_func), s_shape_center,
                    s_shape_size, s_xform_position, s_shape_rotation, s_xform_rotation,
                    s_shape_axis));
            if (m_valid && m_ready) begin
                if (bounds_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: unexpected result center %h extents %h",
                                 m_bounds_center, m_bounds_extents);
                end else begin
                    want = bounds_q.pop_front();
                    if (want.center !== m_bounds_center || want.extents !== m_bounds_extents) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: center exp %h got %h, extents exp %h got %h",
                                     want.center, m_bounds_center,
                                     want.extents, m_bounds_extents);
                    end
                end
            end
        end
        bounds_pending <= bounds_q.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Top of the collider_world_aabb test: clock, reset, stimulus and verdict.
// Depends on cwa_pkg, collider_world_aabb and collider_world_aabb_checker.
module testbench;

    localparam int CB        = cwa_pkg::COORD_BITS;
    localparam int QB        = cwa_pkg::QUAT_BITS;
    localparam int AB        = cwa_pkg::AXIS_BITS;
    localparam int LIMIT     = 200000;
    localparam int RAND_ITEMS = 450;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_func = '0;
    logic [3*CB-1:0]             s_shape_center = '0;
    logic [3*CB-1:0]             s_shape_size = '0;
    logic [4*QB-1:0]             s_shape_rotation = '0;
    logic [3*AB-1:0]             s_shape_axis = '0;
    logic [3*CB-1:0]             s_xform_position = '0;
    logic [4*QB-1:0]             s_xform_rotation = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [3*CB-1:0]             m_bounds_center;
    logic [3*CB-1:0]             m_bounds_extents;
    int                          fail_count;
    int                          bounds_pending;
    int                          cycles = 0;
    int                          hold_cycles = 0;

    always #5 aclk = ~aclk;

    collider_world_aabb u_top (.*);

    collider_world_aabb_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: free-running windows, random stalls, one long hold-off
    always @(posedge aclk) begin
        int r;
        if (cycles == 600) begin
            hold_cycles <= 200;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (cycles % 512 < 100) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            m_ready <= (r >= 25);
            if (r == 0) hold_cycles <= $urandom_range(10, 30);
        end
    end

    function automatic logic [4*QB-1:0] quat(input int w, x, y, z);
        return {QB'(z), QB'(y), QB'(x), QB'(w)};
    endfunction

    function automatic logic [3*CB-1:0] vec(input int x, y, z);
        return {CB'(z), CB'(y), CB'(x)};
    endfunction

    function automatic logic [4*QB-1:0] rand_quat();
        case ($urandom_range(0, 3))
            0: return quat(8192, 0, 0, 0);
            1: return quat(5793, $urandom_range(0, 1) ? 5793 : -5793, 0, 0);
            2: return (4*QB)'({$urandom, $urandom});
            default: return quat($urandom_range(0, 16383) - 8192, $urandom_range(0, 8191) - 4096,
                                 $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic logic [3*CB-1:0] rand_coord();
        if ($urandom_range(0, 1)) return (3*CB)'({$urandom, $urandom});
        return vec($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                   $urandom_range(0, 4095) - 2048);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input cwa_pkg::kind_t kind, input logic [3*CB-1:0] ctr, size, pos,
                        input logic [4*QB-1:0] qb, qx,
                        input logic [3*AB-1:0] ax, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_func           <= kind;
        s_shape_center   <= ctr;
        s_shape_size     <= size;
        s_shape_rotation <= qb;
        s_shape_axis     <= ax;
        s_xform_position <= pos;
        s_xform_rotation <= qx;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        logic [4*QB-1:0] id_q, max_q, min_q;
        logic [3*CB-1:0] ones, max_v, min_v;
        int guard;
        id_q  = quat(8192, 0, 0, 0);
        max_q = quat(16383, 16383, 16383, 16383);
        min_q = quat(-16384, -16384, -16384, -16384);
        ones  = '1;
        max_v = vec(32767, 32767, 32767);
        min_v = vec(-32768, -32768, -32768);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // each kind, identity transforms
        send(cwa_pkg::KIND_PLANE, vec(256, -256, 512), vec(256, 256, 256), vec(0, 0, 0),
             id_q, id_q, '0, 0);
        send(cwa_pkg::KIND_SPHERE, vec(0, 0, 0), vec(640, 0, 0), vec(100, 200, -300),
             id_q, id_q, '0, 0);
        send(cwa_pkg::KIND_BOX, vec(0, 0, 0), vec(256, 512, 768), vec(0, 0, 0),
             id_q, id_q, '0, 0);
        send(cwa_pkg::KIND_CAPSULE, vec(0, 0, 0), vec(512, 128, 0), vec(0, 0, 0), id_q, id_q,
             {16'sd0, 16'sd16384, 16'sd0}, 0);
        // negative sizes
        send(cwa_pkg::KIND_SPHERE, '0, vec(-300, 0, 0), '0, id_q, id_q, '0, 1);
        send(cwa_pkg::KIND_BOX, '0, vec(-256, -512, 300), '0, quat(5793, 5793, 0, 0), id_q,
             '0, 0);
        send(cwa_pkg::KIND_CAPSULE, '0, vec(100, -2000, 0), '0, id_q, id_q,
             {16'sd0, 16'sd0, 16'sd16384}, 0);
        // saturation extremes
        send(cwa_pkg::KIND_PLANE, max_v, max_v, max_v, min_q, max_q, '1, 0);
        send(cwa_pkg::KIND_PLANE, min_v, min_v, min_v, max_q, min_q, '0, 0);
        send(cwa_pkg::KIND_SPHERE, ones, max_v, min_v, ones, ones, ones, 2);
        send(cwa_pkg::KIND_BOX, max_v, max_v, max_v, max_q, max_q, '0, 0);
        send(cwa_pkg::KIND_BOX, min_v, min_v, min_v, min_q, min_q, '0, 0);
        send(cwa_pkg::KIND_BOX, ones, ones, ones, ones, ones, ones, 0);
        send(cwa_pkg::KIND_CAPSULE, max_v, max_v, max_v, max_q, max_q,
             {16'h7fff, 16'h7fff, 16'h7fff}, 0);
        send(cwa_pkg::KIND_CAPSULE, min_v, min_v, min_v, min_q, min_q,
             {16'h8000, 16'h8000, 16'h8000}, 0);
        send(cwa_pkg::KIND_CAPSULE, '0, vec(32767, 32767, 0), '0, id_q, id_q,
             {16'h8000, 16'h0000, 16'h0000}, 0);
        // zero and unnormalized quaternions
        send(cwa_pkg::KIND_BOX, vec(256, 256, 256), vec(256, 256, 256), '0, '0, '0, '0, 0);
        send(cwa_pkg::KIND_SPHERE, vec(256, 0, 0), vec(256, 0, 0), '0, id_q,
             quat(16383, 0, 0, 0), '0, 0);
        send(cwa_pkg::KIND_CAPSULE, vec(-1, -1, -1), vec(1, 1, 1), '0, id_q,
             quat(5793, 0, 5793, 0), {16'sd11585, 16'sd11585, 16'sd0}, 3);

        for (int n = 0; n < RAND_ITEMS; n++)
            send(cwa_pkg::kind_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                 rand_coord(), rand_quat(), rand_quat(), (3*AB)'({$urandom, $urandom}),
                 (n >= 200 && n < 260) ? 0 : gap_len());
        s_valid <= 1'b0;

        @(posedge aclk);
        guard = 0;
        while (bounds_pending != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && bounds_pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> collider_world_aabb.f
rtl/cwa_pkg.sv
rtl/collider_world_aabb.sv
rtl/cwa_checker.sv
test/collider_world_aabb_checker.sv
test/testbench.sv
